FILE: hdl/frp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frp_pkg: shared types and constants for the fitness roulette population
// Holds field widths, command codes and the control/status bundles that
// pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package frp_pkg;

    localparam int FIT_W     = 32;
    localparam int DRAW_W    = 16;
    localparam int IDX_OUT_W = 4;
    localparam int CNT_OUT_W = 5;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_SELECT = 1'b1;

    // Read address source for the store.
    typedef enum logic [1:0] {
        RA_ZERO = 2'd0,
        RA_TOP  = 2'd1,
        RA_DN   = 2'd2,
        RA_UP   = 2'd3
    } t_rd_sel;

    // Write address source for the store.
    typedef enum logic [1:0] {
        WA_ZERO = 2'd0,
        WA_DN   = 2'd1,
        WA_UP   = 2'd2
    } t_wr_sel;

    typedef struct packed {
        logic    load;
        logic    ptr_clr;
        logic    ptr_top;
        logic    ptr_inc;
        logic    ptr_dec;
        t_rd_sel rd_sel;
        logic    wr_en;
        t_wr_sel wr_sel;
        logic    wr_val;
        logic    cnt_inc;
        logic    set_acc;
        logic    sum_acc;
        logic    tgt_a;
        logic    tgt_b;
        logic    scan;
        logic    out_load;
    } t_frp_cmd;

    typedef struct packed {
        logic is_select;
        logic cnt_zero;
        logic cnt_full;
        logic lt;
        logic ptr_zero;
        logic ptr_last;
        logic ptr_end;
        logic out_free;
    } t_frp_status;

endpackage

FILE: hdl/frp_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frp_ram: generic single-write, single-read memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module frp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: hdl/frp_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frp_ctrl: sequencing state machine
// Walks the store for inserts and runs the sum, target and scan passes
// for selects, driving the datapath through a command bundle.
// ----------------------------------------------------------------------------
module frp_ctrl
    import frp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_frp_status i_sts,
    output t_frp_cmd    o_ctl
);

    typedef enum logic [10:0] {
        S_IDLE     = 11'b000_0000_0001,
        S_DECODE   = 11'b000_0000_0010,
        S_INS_UP   = 11'b000_0000_0100,
        S_INS_FIN  = 11'b000_0000_1000,
        S_FULL_CHK = 11'b000_0001_0000,
        S_INS_DN   = 11'b000_0010_0000,
        S_SUM      = 11'b000_0100_0000,
        S_MUL_A    = 11'b000_1000_0000,
        S_MUL_B    = 11'b001_0000_0000,
        S_SCAN     = 11'b010_0000_0000,
        S_OUT      = 11'b100_0000_0000
    } t_state;

    t_state   r_state;
    t_state   n_state;
    t_frp_cmd w_ctl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        w_ctl   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    w_ctl.load = 1'b1;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                if (i_sts.is_select) begin
                    if (i_sts.cnt_zero) begin
                        n_state = S_OUT;
                    end else begin
                        w_ctl.ptr_clr = 1'b1;
                        w_ctl.rd_sel  = RA_ZERO;
                        n_state       = S_SUM;
                    end
                end else if (i_sts.cnt_zero) begin
                    w_ctl.wr_en   = 1'b1;
                    w_ctl.wr_sel  = WA_ZERO;
                    w_ctl.wr_val  = 1'b1;
                    w_ctl.cnt_inc = 1'b1;
                    w_ctl.set_acc = 1'b1;
                    n_state       = S_OUT;
                end else if (!i_sts.cnt_full) begin
                    w_ctl.ptr_top = 1'b1;
                    w_ctl.rd_sel  = RA_TOP;
                    n_state       = S_INS_UP;
                end else begin
                    w_ctl.ptr_clr = 1'b1;
                    w_ctl.rd_sel  = RA_ZERO;
                    n_state       = S_FULL_CHK;
                end
            end
            S_INS_UP: begin
                w_ctl.wr_en  = 1'b1;
                w_ctl.wr_sel = WA_UP;
                if (i_sts.lt) begin
                    w_ctl.wr_val  = 1'b1;
                    w_ctl.cnt_inc = 1'b1;
                    w_ctl.set_acc = 1'b1;
                    n_state       = S_OUT;
                end else if (i_sts.ptr_zero) begin
                    n_state = S_INS_FIN;
                end else begin
                    w_ctl.ptr_dec = 1'b1;
                    w_ctl.rd_sel  = RA_DN;
                end
            end
            S_INS_FIN: begin
                w_ctl.wr_en   = 1'b1;
                w_ctl.wr_sel  = WA_ZERO;
                w_ctl.wr_val  = 1'b1;
                w_ctl.cnt_inc = 1'b1;
                w_ctl.set_acc = 1'b1;
                n_state       = S_OUT;
            end
            S_FULL_CHK: begin
                if (i_sts.lt) begin
                    w_ctl.ptr_inc = 1'b1;
                    w_ctl.rd_sel  = RA_UP;
                    n_state       = S_INS_DN;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_INS_DN: begin
                w_ctl.wr_en  = 1'b1;
                w_ctl.wr_sel = WA_DN;
                if (!i_sts.ptr_end && i_sts.lt) begin
                    w_ctl.ptr_inc = 1'b1;
                    w_ctl.rd_sel  = RA_UP;
                end else begin
                    w_ctl.wr_val  = 1'b1;
                    w_ctl.set_acc = 1'b1;
                    n_state       = S_OUT;
                end
            end
            S_SUM: begin
                w_ctl.sum_acc = 1'b1;
                if (i_sts.ptr_last) begin
                    n_state = S_MUL_A;
                end else begin
                    w_ctl.ptr_inc = 1'b1;
                    w_ctl.rd_sel  = RA_UP;
                end
            end
            S_MUL_A: begin
                w_ctl.tgt_a = 1'b1;
                n_state     = S_MUL_B;
            end
            S_MUL_B: begin
                w_ctl.tgt_b   = 1'b1;
                w_ctl.ptr_clr = 1'b1;
                w_ctl.rd_sel  = RA_ZERO;
                n_state       = S_SCAN;
            end
            S_SCAN: begin
                w_ctl.scan = 1'b1;
                if (i_sts.ptr_last) begin
                    n_state = S_OUT;
                end else begin
                    w_ctl.ptr_inc = 1'b1;
                    w_ctl.rd_sel  = RA_UP;
                end
            end
            S_OUT: begin
                if (i_sts.out_free) begin
                    w_ctl.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_ctl      = w_ctl;
    assign o_in_stall = (r_state != S_IDLE);

endmodule

FILE: hdl/frp_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frp_datapath: store, pointer, sums and result register
// Holds the sorted fitness store, the entry count, the walk pointer, the
// running sums, the selection targets and the output register.
// ----------------------------------------------------------------------------
module frp_datapath
    import frp_pkg::*;
#(
    parameter int POP_SIZE = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_frp_cmd             i_ctl,
    output t_frp_status          o_sts,
    input  logic                 i_cmd,
    input  logic [FIT_W-1:0]     i_fitness_value,
    input  logic [DRAW_W-1:0]    i_draw_a,
    input  logic [DRAW_W-1:0]    i_draw_b,
    input  logic                 i_out_stall,
    output logic                 o_out_valid,
    output logic                 o_accepted,
    output logic [IDX_OUT_W-1:0] o_index_a,
    output logic [IDX_OUT_W-1:0] o_index_b,
    output logic [CNT_OUT_W-1:0] o_pop_count
);

    localparam int IDX_W = $clog2(POP_SIZE);
    localparam int CNT_W = $clog2(POP_SIZE + 1);
    localparam int TOT_W = FIT_W + IDX_W;
    localparam int TGT_W = TOT_W + DRAW_W;
    localparam int XI_W  = (IDX_W > IDX_OUT_W) ? IDX_W : IDX_OUT_W;
    localparam int XC_W  = (CNT_W > CNT_OUT_W) ? CNT_W : CNT_OUT_W;

    logic                 r_cmd;
    logic [FIT_W-1:0]     r_val;
    logic [DRAW_W-1:0]    r_da;
    logic [DRAW_W-1:0]    r_db;
    logic [CNT_W-1:0]     r_count;
    logic [CNT_W-1:0]     r_ptr;
    logic [TOT_W-1:0]     r_total;
    logic [TOT_W-1:0]     r_run;
    logic [TGT_W-1:0]     r_tgt_a;
    logic [TGT_W-1:0]     r_tgt_b;
    logic [IDX_W-1:0]     r_idx_a;
    logic [IDX_W-1:0]     r_idx_b;
    logic                 r_found_a;
    logic                 r_found_b;
    logic                 r_acc;
    logic                 r_out_valid;
    logic                 r_out_acc;
    logic [IDX_OUT_W-1:0] r_out_idx_a;
    logic [IDX_OUT_W-1:0] r_out_idx_b;
    logic [CNT_OUT_W-1:0] r_out_cnt;

    logic [FIT_W-1:0]  w_rdata;
    logic [FIT_W-1:0]  w_wdata;
    logic [IDX_W-1:0]  w_raddr;
    logic [IDX_W-1:0]  w_waddr;
    logic [CNT_W-1:0]  w_cnt_m1;
    logic [CNT_W-1:0]  w_ptr_m1;
    logic [CNT_W-1:0]  w_ptr_p1;
    logic [DRAW_W-1:0] w_mul_draw;
    logic [TGT_W-1:0]  w_prod;
    logic [TOT_W-1:0]  w_run_nx;
    logic [TGT_W-1:0]  w_run_sh;
    logic              w_hit_a;
    logic              w_hit_b;
    logic              w_out_free;
    logic [XI_W-1:0]   w_ia_ext;
    logic [XI_W-1:0]   w_ib_ext;
    logic [XC_W-1:0]   w_cnt_ext;

    assign w_cnt_m1 = r_count - 1'b1;
    assign w_ptr_m1 = r_ptr - 1'b1;
    assign w_ptr_p1 = r_ptr + 1'b1;

    always_comb begin
        case (i_ctl.rd_sel)
            RA_ZERO: w_raddr = '0;
            RA_TOP:  w_raddr = w_cnt_m1[IDX_W-1:0];
            RA_DN:   w_raddr = w_ptr_m1[IDX_W-1:0];
            RA_UP:   w_raddr = w_ptr_p1[IDX_W-1:0];
            default: w_raddr = '0;
        endcase
    end

    always_comb begin
        case (i_ctl.wr_sel)
            WA_ZERO: w_waddr = '0;
            WA_DN:   w_waddr = w_ptr_m1[IDX_W-1:0];
            WA_UP:   w_waddr = w_ptr_p1[IDX_W-1:0];
            default: w_waddr = '0;
        endcase
    end

    assign w_wdata = i_ctl.wr_val ? r_val : w_rdata;

    frp_ram #(
        .WIDTH (FIT_W),
        .DEPTH (POP_SIZE)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (i_ctl.wr_en),
        .i_wr_addr (w_waddr),
        .i_wr_data (w_wdata),
        .i_rd_addr (w_raddr),
        .o_rd_data (w_rdata)
    );

    // One shared multiplier forms draw times total for each draw in turn.
    assign w_mul_draw = i_ctl.tgt_b ? r_db : r_da;
    assign w_prod     = TGT_W'(w_mul_draw) * TGT_W'(r_total);

    assign w_run_nx = r_run + TOT_W'(w_rdata);
    assign w_run_sh = {w_run_nx, {DRAW_W{1'b0}}};
    assign w_hit_a  = (w_run_sh >= r_tgt_a);
    assign w_hit_b  = (w_run_sh >= r_tgt_b);

    assign w_out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_ctl.cnt_inc) begin
            r_count <= r_count + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_cmd     <= i_cmd;
            r_val     <= i_fitness_value;
            r_da      <= i_draw_a;
            r_db      <= i_draw_b;
            r_total   <= '0;
            r_run     <= '0;
            r_idx_a   <= '0;
            r_idx_b   <= '0;
            r_found_a <= 1'b0;
            r_found_b <= 1'b0;
            r_acc     <= 1'b0;
        end else begin
            if (i_ctl.set_acc) begin
                r_acc <= 1'b1;
            end
            if (i_ctl.sum_acc) begin
                r_total <= r_total + TOT_W'(w_rdata);
            end
            if (i_ctl.tgt_a) begin
                r_tgt_a <= w_prod;
            end
            if (i_ctl.tgt_b) begin
                r_tgt_b <= w_prod;
            end
            if (i_ctl.scan) begin
                r_run <= w_run_nx;
                if (!r_found_a && w_hit_a) begin
                    r_found_a <= 1'b1;
                    r_idx_a   <= r_ptr[IDX_W-1:0];
                end
                if (!r_found_b && w_hit_b) begin
                    r_found_b <= 1'b1;
                    r_idx_b   <= r_ptr[IDX_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ptr_clr) begin
            r_ptr <= '0;
        end else if (i_ctl.ptr_top) begin
            r_ptr <= w_cnt_m1;
        end else if (i_ctl.ptr_inc) begin
            r_ptr <= w_ptr_p1;
        end else if (i_ctl.ptr_dec) begin
            r_ptr <= w_ptr_m1;
        end
    end

    // Indices and count are reported in their low bits only.
    assign w_ia_ext  = XI_W'(r_idx_a);
    assign w_ib_ext  = XI_W'(r_idx_b);
    assign w_cnt_ext = XC_W'(r_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctl.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.out_load) begin
            r_out_acc   <= r_acc;
            r_out_idx_a <= w_ia_ext[IDX_OUT_W-1:0];
            r_out_idx_b <= w_ib_ext[IDX_OUT_W-1:0];
            r_out_cnt   <= w_cnt_ext[CNT_OUT_W-1:0];
        end
    end

    assign o_sts.is_select = (r_cmd == CMD_SELECT);
    assign o_sts.cnt_zero  = (r_count == '0);
    assign o_sts.cnt_full  = (r_count == CNT_W'(POP_SIZE));
    assign o_sts.lt        = (w_rdata < r_val);
    assign o_sts.ptr_zero  = (r_ptr == '0);
    assign o_sts.ptr_last  = (r_ptr == w_cnt_m1);
    assign o_sts.ptr_end   = (r_ptr == CNT_W'(POP_SIZE));
    assign o_sts.out_free  = w_out_free;

    assign o_out_valid = r_out_valid;
    assign o_accepted  = r_out_acc;
    assign o_index_a   = r_out_idx_a;
    assign o_index_b   = r_out_idx_b;
    assign o_pop_count = r_out_cnt;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(POP_SIZE))
        else $error("entry count above population size");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && (r_count != $past(r_count)) |->
        r_count == $past(r_count) + 1'b1)
        else $error("entry count changed by other than one");

    a_out_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.out_load |-> !r_out_valid || !i_out_stall)
        else $error("result register loaded while a stalled result waits");

    a_accept_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.out_load && r_acc |-> r_count != '0)
        else $error("accepted insert left an empty population");

    a_index_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.out_load && (r_cmd == CMD_SELECT) && (r_count != '0) |->
        (CNT_W'(r_idx_a) < r_count) && (CNT_W'(r_idx_b) < r_count))
        else $error("selected index beyond valid entries");

endmodule

FILE: hdl/fitness_roulette_population_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fitness_roulette_population_top: sorted population with roulette selection
// Keeps up to POP_SIZE fitness values in ascending order, inserts new
// values in place, and picks two indices by fitness-proportional draws.
// ----------------------------------------------------------------------------
//
//  Channel  Valid        Stall         Payload
//  -------  -----------  ------------  ---------------------------------------
//  input    i_in_valid   o_in_stall    i_cmd, i_fitness_value, i_draw_a/b
//  output   o_out_valid  i_out_stall   o_accepted, o_index_a/b, o_pop_count
//
// One item is in work at a time; the store has a single write and a single
// read port, so every walk moves one entry per cycle. A select runs a sum
// pass, a multiply step for each draw and a scan pass. Reset is synchronous
// and active low; it empties the population and needs no clearing pass.
// o_in_stall is high from the cycle after an item is taken until its result
// enters the result register. The next item is taken while a finished
// result still waits under i_out_stall; its own result then waits until
// that register is free.
//
module fitness_roulette_population_top
    import frp_pkg::*;
#(
    parameter int POP_SIZE = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,

    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic                 i_cmd,
    input  logic [FIT_W-1:0]     i_fitness_value,
    input  logic [DRAW_W-1:0]    i_draw_a,
    input  logic [DRAW_W-1:0]    i_draw_b,

    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic                 o_accepted,
    output logic [IDX_OUT_W-1:0] o_index_a,
    output logic [IDX_OUT_W-1:0] o_index_b,
    output logic [CNT_OUT_W-1:0] o_pop_count
);

    // Commands flow from the controller, status flows back.
    t_frp_cmd    w_ctl;
    t_frp_status w_sts;

    // The controller sequences the insert walks (shifting entries up when
    // the store has room, down when the minimum is being dropped) and the
    // select passes over the store.
    frp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (w_sts),
        .o_ctl      (w_ctl)
    );

    // The datapath owns the store, the count, the sums, the targets and the
    // result register that decouples the output channel.
    frp_datapath #(
        .POP_SIZE (POP_SIZE)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_ctl           (w_ctl),
        .o_sts           (w_sts),
        .i_cmd           (i_cmd),
        .i_fitness_value (i_fitness_value),
        .i_draw_a        (i_draw_a),
        .i_draw_b        (i_draw_b),
        .i_out_stall     (i_out_stall),
        .o_out_valid     (o_out_valid),
        .o_accepted      (o_accepted),
        .o_index_a       (o_index_a),
        .o_index_b       (o_index_b),
        .o_pop_count     (o_pop_count)
    );

endmodule

FILE: dv/fitness_roulette_population_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fitness_roulette_population_top_tb: self-checking bench for the population
// Feeds insert and select items through the valid/stall input channel,
// predicts every result from a private copy of the sorted population, and
// checks each result item field by field as it leaves the block.
// ----------------------------------------------------------------------------
module fitness_roulette_population_top_tb
    import frp_pkg::*;
();

    localparam int POP_SIZE    = 16;
    localparam int CYCLE_LIMIT = 1000000;
    // Drain wait after the last item, with margin over the longest select.
    localparam int DRAIN_WAIT  = 100;
    localparam int HOLD_CYCLES = 400;
    localparam int NUM_RANDOM  = 1624;

    // One input item as it travels over the input channel.
    typedef struct packed {
        logic              cmd;
        logic [FIT_W-1:0]  fitness;
        logic [DRAW_W-1:0] draw_a;
        logic [DRAW_W-1:0] draw_b;
    } t_fitness_item;

    // One result item as it leaves the block.
    typedef struct packed {
        logic                 accepted;
        logic [IDX_OUT_W-1:0] index_a;
        logic [IDX_OUT_W-1:0] index_b;
        logic [CNT_OUT_W-1:0] pop_count;
    } t_selection_result;

    // Clock, reset and block ports. Every input starts at a known value.
    logic                 i_clk           = 1'b0;
    logic                 i_rst_n         = 1'b0;
    logic                 i_in_valid      = 1'b0;
    logic                 o_in_stall;
    logic                 i_cmd           = CMD_INSERT;
    logic [FIT_W-1:0]     i_fitness_value = '0;
    logic [DRAW_W-1:0]    i_draw_a        = '0;
    logic [DRAW_W-1:0]    i_draw_b        = '0;
    logic                 o_out_valid;
    logic                 i_out_stall     = 1'b0;
    logic                 o_accepted;
    logic [IDX_OUT_W-1:0] o_index_a;
    logic [IDX_OUT_W-1:0] o_index_b;
    logic [CNT_OUT_W-1:0] o_pop_count;

    // Items waiting to be offered, and results predicted but not yet seen.
    t_fitness_item     pending_items[$];
    t_selection_result predicted_results[$];

    // Private copy of the population. Entries at and above pop_cnt are never
    // read, so the store needs no reset of its own.
    logic [FIT_W-1:0]  pop_store [POP_SIZE];
    int                pop_cnt = 0;

    int                mismatch_cnt = 0;
    int                cycle_cnt    = 0;
    int                idle_pct     = 35;
    logic              fire_in      = 1'b0;
    logic              hold_go      = 1'b0;
    logic              hold_done    = 1'b0;
    int                hold_left    = 0;

    fitness_roulette_population_top #(
        .POP_SIZE        (POP_SIZE)
    ) i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_cmd           (i_cmd),
        .i_fitness_value (i_fitness_value),
        .i_draw_a        (i_draw_a),
        .i_draw_b        (i_draw_b),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_accepted      (o_accepted),
        .o_index_a       (o_index_a),
        .o_index_b       (o_index_b),
        .o_pop_count     (o_pop_count)
    );

    // 20 ns period: 10 ns low, then 10 ns high.
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Roulette walk over the sorted population. The first entry whose
    // inclusive prefix sum, scaled by 2^16, reaches draw * total wins. A zero
    // total, or a walk that never reaches the target, picks entry 0.
    function automatic logic [IDX_OUT_W-1:0] spin_index(logic [DRAW_W-1:0] draw,
                                                        logic [39:0] total);
        logic [63:0] target;
        logic [63:0] run;
        target = 64'(draw) * 64'(total);
        run    = '0;
        if (total == '0) begin
            return '0;
        end
        for (int k = 0; k < pop_cnt; k++) begin
            run = run + 64'(pop_store[k]);
            if ((run << 16) >= target) begin
                return IDX_OUT_W'(k);
            end
        end
        return '0;
    endfunction

    // Applies one accepted item to the private population and returns the
    // result item the block must produce for it.
    function automatic t_selection_result apply_to_population(t_fitness_item it);
        t_selection_result res;
        int                slot;
        logic [39:0]       total;
        res   = '0;
        slot  = 0;
        total = '0;
        if (it.cmd == CMD_INSERT) begin
            // Slot is the first entry that is not smaller than the value.
            while (slot < pop_cnt && pop_store[slot] < it.fitness) begin
                slot++;
            end
            if (pop_cnt < POP_SIZE) begin
                for (int k = pop_cnt; k > slot; k--) begin
                    pop_store[k] = pop_store[k-1];
                end
                pop_store[slot] = it.fitness;
                pop_cnt++;
                res.accepted = 1'b1;
            end else if (it.fitness > pop_store[0]) begin
                // Full store: the minimum drops out and the lower part
                // slides down by one to open the slot below the insert point.
                for (int k = 0; k < slot - 1; k++) begin
                    pop_store[k] = pop_store[k+1];
                end
                pop_store[slot-1] = it.fitness;
                res.accepted = 1'b1;
            end
        end else begin
            for (int k = 0; k < pop_cnt; k++) begin
                total = total + 40'(pop_store[k]);
            end
            res.index_a = spin_index(it.draw_a, total);
            res.index_b = spin_index(it.draw_b, total);
        end
        res.pop_count = CNT_OUT_W'(pop_cnt);
        return res;
    endfunction

    // Counts a mismatch; only the first few are described in the log.
    task automatic note_mismatch(string what, int unsigned expd, int unsigned got);
        mismatch_cnt++;
        if (mismatch_cnt <= 10) begin
            $display("%0t: %s mismatch: expected %0d, got %0d", $realtime, what, expd, got);
        end
    endtask

    // Waits for a rising edge and lets every update it causes settle.
    task automatic tick();
        @(posedge i_clk);
        #1;
    endtask

    // Keeps the item queue short so that generated values can look at the
    // population as it stands, then queues the item.
    task automatic queue_item(logic cmd, logic [FIT_W-1:0] fitness,
                              logic [DRAW_W-1:0] draw_a, logic [DRAW_W-1:0] draw_b);
        t_fitness_item it;
        it.cmd     = cmd;
        it.fitness = fitness;
        it.draw_a  = draw_a;
        it.draw_b  = draw_b;
        while (pending_items.size() >= 4) begin
            tick();
        end
        pending_items = {pending_items, it};
    endtask

    // Waits until every queued item has been taken and every result is back.
    task automatic wait_quiet();
        while (pending_items.size() != 0 || i_in_valid || predicted_results.size() != 0) begin
            tick();
        end
    endtask

    // Input side. At each rising edge an item moves if valid is high and the
    // block is not stalling; that is where the prediction is made. At the
    // output, every item that leaves is checked against the oldest prediction.
    always @(posedge i_clk) begin : edge_monitor
        t_fitness_item     taken;
        t_selection_result seen;
        t_selection_result want;
        fire_in <= i_rst_n && i_in_valid && !o_in_stall;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                taken.cmd     = i_cmd;
                taken.fitness = i_fitness_value;
                taken.draw_a  = i_draw_a;
                taken.draw_b  = i_draw_b;
                predicted_results = {predicted_results, apply_to_population(taken)};
            end
            if (o_out_valid && !i_out_stall) begin
                seen.accepted  = o_accepted;
                seen.index_a   = o_index_a;
                seen.index_b   = o_index_b;
                seen.pop_count = o_pop_count;
                if (predicted_results.size() == 0) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10) begin
                        $display("%0t: result item with nothing expected", $realtime);
                    end
                end else begin
                    want = predicted_results.pop_front();
                    if (seen.accepted != want.accepted) begin
                        note_mismatch("accepted", 32'(want.accepted), 32'(seen.accepted));
                    end
                    if (seen.index_a != want.index_a) begin
                        note_mismatch("index_a", 32'(want.index_a), 32'(seen.index_a));
                    end
                    if (seen.index_b != want.index_b) begin
                        note_mismatch("index_b", 32'(want.index_b), 32'(seen.index_b));
                    end
                    if (seen.pop_count != want.pop_count) begin
                        note_mismatch("pop_count", 32'(want.pop_count),
                                      32'(seen.pop_count));
                    end
                end
            end
        end
    end

    // Sender. A stalled item is held unchanged; otherwise the next queued
    // item goes out unless this cycle is chosen to idle.
    always @(negedge i_clk) begin : item_driver
        t_fitness_item nxt;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (i_in_valid && !fire_in) begin
            i_in_valid <= 1'b1;
        end else if (pending_items.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
            nxt = pending_items.pop_front();
            i_in_valid      <= 1'b1;
            i_cmd           <= nxt.cmd;
            i_fitness_value <= nxt.fitness;
            i_draw_a        <= nxt.draw_a;
            i_draw_b        <= nxt.draw_b;
        end else begin
            i_in_valid <= 1'b0;
        end
    end

    // Receiver. Normally stalls at random; once, on request, it holds off for
    // a long stretch so that the block fills up and stalls its input.
    always @(negedge i_clk) begin : result_stall
        if (hold_left > 0) begin
            hold_left   <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else if (hold_go && !hold_done) begin
            hold_left   <= HOLD_CYCLES;
            hold_done   <= 1'b1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < idle_pct);
        end
    end

    // Watchdog: a run that hangs ends as a failure.
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Stimulus: a directed opening, then random items.
    initial begin : stimulus
        logic [FIT_W-1:0]  fill_vals [12];
        logic [FIT_W-1:0]  base;
        logic [FIT_W-1:0]  val;
        logic [DRAW_W-1:0] da;
        logic [DRAW_W-1:0] db;
        logic              cmd;
        int                pick;

        fill_vals = '{32'h8000_0000, 32'h7FFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555,
                      32'd1, 32'd2, 32'd3, 32'h0001_0000,
                      32'hFFFF_0000, 32'h0000_FFFF, 32'd100, 32'hFFFF_FFFE};

        // Reset is held from the start and released at a falling edge.
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        tick();

        // Select on the empty population: both indices must come back 0.
        queue_item(CMD_SELECT, 32'h1234_5678, 16'hFFFF, 16'h8000);
        // A population whose only entry is zero still has a zero total.
        queue_item(CMD_INSERT, 32'd0, 16'h0000, 16'h0000);
        queue_item(CMD_SELECT, 32'd0, 16'h8000, 16'hFFFF);
        // Largest value, then a duplicate pair.
        queue_item(CMD_INSERT, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
        queue_item(CMD_INSERT, 32'd5, 16'h0000, 16'h0000);
        queue_item(CMD_INSERT, 32'd5, 16'h0000, 16'h0000);
        // A zero draw picks the first entry; the largest draw walks to the top.
        queue_item(CMD_SELECT, 32'hFFFF_FFFF, 16'h0000, 16'hFFFF);
        queue_item(CMD_SELECT, 32'd0, 16'h0001, 16'h8000);
        // Fill the store to capacity.
        foreach (fill_vals[k]) begin
            queue_item(CMD_INSERT, fill_vals[k], 16'h0000, 16'h0000);
        end
        // Full store: equal to the minimum is rejected, above it replaces it.
        queue_item(CMD_INSERT, 32'd0, 16'h0000, 16'h0000);
        queue_item(CMD_INSERT, 32'd7, 16'h0000, 16'h0000);
        // Below, then equal to, the new minimum: both rejected.
        queue_item(CMD_INSERT, 32'd0, 16'h0000, 16'h0000);
        queue_item(CMD_INSERT, 32'd1, 16'h0000, 16'h0000);
        // A new maximum while full drops the minimum and lands at the top.
        queue_item(CMD_INSERT, 32'hFFFF_FFFF, 16'h0000, 16'h0000);
        queue_item(CMD_SELECT, 32'd0, 16'h0000, 16'hFFFF);

        for (int n = 0; n < NUM_RANDOM; n++) begin
            // Once the sender pauses until every result is home, later a
            // stretch runs with no idling, and once the receiver holds off.
            if (n == 400) begin
                wait_quiet();
            end
            if (n == 700) begin
                idle_pct = 0;
            end
            if (n == 1000) begin
                idle_pct = 35;
            end
            if (n == 1200) begin
                hold_go = 1'b1;
            end

            cmd  = ($urandom_range(0, 1) == 1) ? CMD_SELECT : CMD_INSERT;
            val  = $urandom();
            da   = DRAW_W'($urandom_range(0, 16'hFFFF));
            db   = DRAW_W'($urandom_range(0, 16'hFFFF));
            pick = $urandom_range(0, 99);

            // Inserts favor values around the current minimum, where the
            // full-store accept and reject decisions are made.
            if (cmd == CMD_INSERT) begin
                base = (pop_cnt > 0) ? pop_store[0] : '0;
                if (pick < 30) begin
                    val = $urandom();
                end else if (pick < 50) begin
                    val = $urandom_range(0, 255);
                end else if (pick < 80) begin
                    val = base + $urandom_range(0, 4) - 2;
                end else if (pick < 90) begin
                    val = 32'hFFFF_FFFF - $urandom_range(0, 3);
                end else begin
                    val = '0;
                end
            end else begin
                if (pick < 10) begin
                    da = '0;
                end else if (pick < 20) begin
                    db = 16'hFFFF;
                end
            end
            queue_item(cmd, val, da, db);
        end

        wait_quiet();
        repeat (DRAIN_WAIT) tick();

        if (mismatch_cnt == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

FILE: filelist.f
hdl/frp_pkg.sv
hdl/frp_ram.sv
hdl/frp_ctrl.sv
hdl/frp_datapath.sv
hdl/fitness_roulette_population_top.sv
dv/fitness_roulette_population_top_tb.sv
